// ===== rtl/core/yuvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types, register map and coefficient tables for the YCbCr to RGB
// pixel converter.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    localparam int unsigned PIX_W  = 8;   // one color byte
    localparam int unsigned COEF_W = 18;  // Q16 coefficients fit in 18 bits
    localparam int unsigned ACC_W  = 28;  // Y*65536 plus two products, signed
    localparam int unsigned RES_W  = ACC_W - 16;
    localparam int unsigned CNT_W  = 2;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // register indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_MATRIX_STANDARD   = 2'd0,
        REG_ARITHMETIC_METHOD = 2'd1,
        REG_OUTPUT_FORMAT     = 2'd2,
        REG_BYTE_ORDER        = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MAT_PLAIN = 2'd0,
        MAT_BT601 = 2'd1,
        MAT_BT709 = 2'd2
    } t_matrix;

    typedef enum logic [1:0] {
        METH_PRECISE  = 2'd0,
        METH_COMBINED = 2'd1,
        METH_PER_TERM = 2'd2
    } t_method;

    typedef enum logic {
        FMT_RGB565 = 1'b0,
        FMT_RGB24  = 1'b1
    } t_format;

    typedef enum logic {
        ORDER_LITTLE = 1'b0,
        ORDER_BIG    = 1'b1
    } t_order;

    localparam logic [CNT_W-1:0] BYTES_RGB565 = 2'd2;
    localparam logic [CNT_W-1:0] BYTES_RGB24  = 2'd3;

    typedef struct packed {
        logic [1:0] matrix_standard;
        logic [1:0] arithmetic_method;
        logic       output_format;
        logic       byte_order;
    } t_cfg;

    typedef struct packed {
        logic [COEF_W-1:0] rv;
        logic [COEF_W-1:0] gu;
        logic [COEF_W-1:0] gv;
        logic [COEF_W-1:0] bu;
    } t_coef;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [PIX_W-1:0] byte_first;
        logic [PIX_W-1:0] byte_second;
        logic [PIX_W-1:0] byte_third;
        logic [CNT_W-1:0] byte_count;
    } t_bytes;

    // 8-bit-scaled coefficients, returned in Q16 (shifted up by 8) so that
    // all three methods share the same multipliers.
    function automatic t_coef coef_q8(input logic [1:0] m);
        t_coef c;
        case (m)
            MAT_BT601: c = '{rv: 18'(292 << 8), gu: 18'(101 << 8),
                             gv: 18'(149 << 8), bu: 18'(520 << 8)};
            MAT_BT709: c = '{rv: 18'(328 << 8), gu: 18'(55 << 8),
                             gv: 18'(97 << 8),  bu: 18'(545 << 8)};
            default:   c = '{rv: 18'(351 << 8), gu: 18'(86 << 8),
                             gv: 18'(179 << 8), bu: 18'(444 << 8)};
        endcase
        return c;
    endfunction

    function automatic t_coef coef_q16(input logic [1:0] m);
        t_coef c;
        case (m)
            MAT_BT601: c = '{rv: 18'd74700, gu: 18'd25864,
                             gv: 18'd38050, bu: 18'd133176};
            MAT_BT709: c = '{rv: 18'd83908, gu: 18'd14078,
                             gv: 18'd24942, bu: 18'd139459};
            default:   c = '{rv: 18'd89831, gu: 18'd22127,
                             gv: 18'd45744, bu: 18'd113538};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/yuvrgb_regs.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_regs
// APB register bank holding the converter configuration.
// ----------------------------------------------------------------------------
module yuvrgb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [yuvrgb_pkg::APB_AW-1:0]  paddr,
    input  logic [yuvrgb_pkg::APB_DW-1:0]  pwdata,
    output logic [yuvrgb_pkg::APB_DW-1:0]  prdata,
    output logic                           pready,
    output yuvrgb_pkg::t_cfg               o_cfg
);
    import yuvrgb_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (idx)
                REG_MATRIX_STANDARD:   n_cfg.matrix_standard   = pwdata[1:0];
                REG_ARITHMETIC_METHOD: n_cfg.arithmetic_method = pwdata[1:0];
                REG_OUTPUT_FORMAT:     n_cfg.output_format     = pwdata[0];
                REG_BYTE_ORDER:        n_cfg.byte_order        = pwdata[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_MATRIX_STANDARD:   prdata = {30'd0, r_cfg.matrix_standard};
            REG_ARITHMETIC_METHOD: prdata = {30'd0, r_cfg.arithmetic_method};
            REG_OUTPUT_FORMAT:     prdata = {31'd0, r_cfg.output_format};
            REG_BYTE_ORDER:        prdata = {31'd0, r_cfg.byte_order};
            default:               prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/yuvrgb_matrix.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_matrix
// Color matrix: four Q16 products, method-specific rounding and clamping.
// ----------------------------------------------------------------------------
module yuvrgb_matrix (
    input  yuvrgb_pkg::t_pix_in i_pix,
    input  yuvrgb_pkg::t_cfg    i_cfg,
    output yuvrgb_pkg::t_rgb    o_rgb
);
    import yuvrgb_pkg::*;

    t_method            meth;
    t_coef              coef;
    logic signed [8:0]  u;
    logic signed [8:0]  v;
    logic signed [ACC_W-1:0] p_rv, p_gu, p_gv, p_bu;
    logic signed [ACC_W-1:0] y_q;
    logic signed [ACC_W-1:0] sum_r, sum_g, sum_b;
    logic signed [ACC_W-1:0] bias_r, bias_g, bias_b;
    logic signed [RES_W-1:0] y_s;
    logic signed [RES_W-1:0] res_r, res_g, res_b;

    function automatic logic [PIX_W-1:0] clamp8(input logic signed [RES_W-1:0] x);
        logic [PIX_W-1:0] c;
        if (x < 0) begin
            c = '0;
        end else if (x > $signed(RES_W'(255))) begin
            c = '1;
        end else begin
            c = x[PIX_W-1:0];
        end
        return c;
    endfunction

    // raw chroma minus 128 is the byte with its top bit flipped, sign-extended
    assign u = $signed({{2{~i_pix.chroma_blue[7]}}, i_pix.chroma_blue[6:0]});
    assign v = $signed({{2{~i_pix.chroma_red[7]}}, i_pix.chroma_red[6:0]});

    assign meth = t_method'(i_cfg.arithmetic_method);

    always_comb begin
        case (meth)
            METH_COMBINED, METH_PER_TERM: coef = coef_q8(i_cfg.matrix_standard);
            default:                      coef = coef_q16(i_cfg.matrix_standard);
        endcase
    end

    assign p_rv = $signed({1'b0, coef.rv}) * v;
    assign p_gu = $signed({1'b0, coef.gu}) * u;
    assign p_gv = $signed({1'b0, coef.gv}) * v;
    assign p_bu = $signed({1'b0, coef.bu}) * u;

    assign y_q = $signed({{(ACC_W-PIX_W-16){1'b0}}, i_pix.luma, 16'd0});
    assign y_s = $signed({{(RES_W-PIX_W){1'b0}}, i_pix.luma});

    assign sum_r = y_q + p_rv;
    assign sum_g = y_q - p_gu - p_gv;
    assign sum_b = y_q + p_bu;

    // truncation toward zero: round negative sums up before the shift
    assign bias_r = sum_r + $signed({{(ACC_W-16){1'b0}}, {16{sum_r[ACC_W-1]}}});
    assign bias_g = sum_g + $signed({{(ACC_W-16){1'b0}}, {16{sum_g[ACC_W-1]}}});
    assign bias_b = sum_b + $signed({{(ACC_W-16){1'b0}}, {16{sum_b[ACC_W-1]}}});

    always_comb begin
        case (meth)
            METH_COMBINED: begin
                res_r = sum_r[ACC_W-1:16];
                res_g = sum_g[ACC_W-1:16];
                res_b = sum_b[ACC_W-1:16];
            end
            METH_PER_TERM: begin
                res_r = y_s + $signed(p_rv[ACC_W-1:16]);
                res_g = y_s - $signed(p_gu[ACC_W-1:16]) - $signed(p_gv[ACC_W-1:16]);
                res_b = y_s + $signed(p_bu[ACC_W-1:16]);
            end
            default: begin
                res_r = bias_r[ACC_W-1:16];
                res_g = bias_g[ACC_W-1:16];
                res_b = bias_b[ACC_W-1:16];
            end
        endcase
    end

    assign o_rgb.red   = clamp8(res_r);
    assign o_rgb.green = clamp8(res_g);
    assign o_rgb.blue  = clamp8(res_b);

endmodule

// ===== rtl/core/yuvrgb_pack.sv =====
// ----------------------------------------------------------------------------
// yuvrgb_pack
// Byte packing of one pixel as RGB565 or RGB24 in the configured order.
// ----------------------------------------------------------------------------
module yuvrgb_pack (
    input  yuvrgb_pkg::t_rgb   i_rgb,
    input  yuvrgb_pkg::t_cfg   i_cfg,
    output yuvrgb_pkg::t_bytes o_bytes
);
    import yuvrgb_pkg::*;

    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    t_format          fmt;
    t_order           ord;

    assign fmt = t_format'(i_cfg.output_format);
    assign ord = t_order'(i_cfg.byte_order);
    assign hi  = {i_rgb.red[7:3], i_rgb.green[7:5]};
    assign lo  = {i_rgb.green[4:2], i_rgb.blue[7:3]};

    always_comb begin
        case (fmt)
            FMT_RGB24: begin
                o_bytes.byte_second = i_rgb.green;
                o_bytes.byte_count  = BYTES_RGB24;
                if (ord == ORDER_BIG) begin
                    o_bytes.byte_first = i_rgb.blue;
                    o_bytes.byte_third = i_rgb.red;
                end else begin
                    o_bytes.byte_first = i_rgb.red;
                    o_bytes.byte_third = i_rgb.blue;
                end
            end
            default: begin
                o_bytes.byte_third = '0;
                o_bytes.byte_count = BYTES_RGB565;
                if (ord == ORDER_BIG) begin
                    o_bytes.byte_first  = hi;
                    o_bytes.byte_second = lo;
                end else begin
                    o_bytes.byte_first  = lo;
                    o_bytes.byte_second = hi;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/yuv_to_rgb_pixel_converter_unit.sv =====
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_converter_unit
// YCbCr to RGB converter with selectable matrix, rounding and byte packing.
// ----------------------------------------------------------------------------
// One pixel request per clock: the block accepts a new pixel every cycle
// unless back-pressure reaches the input, and returns it through the input
// register and then the result register. Between the two registers lies the
// single matrix stage (four 18x9 multipliers, adders, rounding and clamp),
// followed by the byte packing. The result register and the input register
// each advance whenever the stage after them is empty or being drained, so a
// stalled output holds at most two pixels and back-pressure reaches the input
// only when both are full. Configuration is read live by the matrix and
// packing logic, so write the registers only while no pixel is in flight.
// Register map (APB, byte addresses): 0x0 matrix_standard (0 plain, 1 BT.601,
// 2 BT.709, 3 acts as plain), 0x4 arithmetic_method (0 precise Q16 truncate,
// 1 combined shift, 2 per-term floor, 3 acts as precise), 0x8 output_format
// (0 RGB565, 1 RGB24), 0xC byte_order (0 little, 1 big). All reset to 0.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_converter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [yuvrgb_pkg::APB_AW-1:0]       paddr,
    input  logic [yuvrgb_pkg::APB_DW-1:0]       pwdata,
    output logic [yuvrgb_pkg::APB_DW-1:0]       prdata,
    output logic                                pready,
    // pixel input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: luma[7:0], chroma_blue[15:8], chroma_red[23:16]
    input  logic [yuvrgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // pixel output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: red[7:0], green[15:8], blue[23:16], byte_first[31:24],
    //        byte_second[39:32], byte_third[47:40], byte_count[49:48], zero above
    output logic [yuvrgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import yuvrgb_pkg::*;

    t_cfg    cfg;
    t_pix_in in_pix;
    t_rgb    rgb;
    t_bytes  bytes;

    // pipeline registers
    logic    r_in_valid;
    t_pix_in r_in_pix;
    logic    r_out_valid;
    t_rgb    r_out_rgb;
    t_bytes  r_out_bytes;

    logic    out_ready;   // result register can take a new pixel
    logic    in_ready;    // input register can take a new pixel

    yuvrgb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_pix.luma        = s_axis_tdata[7:0];
    assign in_pix.chroma_blue = s_axis_tdata[15:8];
    assign in_pix.chroma_red  = s_axis_tdata[23:16];

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign in_ready      = !r_in_valid || out_ready;
    assign s_axis_tready = in_ready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && s_axis_tvalid) begin
            r_in_pix <= in_pix;
        end
    end

    yuvrgb_matrix u_matrix (
        .i_pix (r_in_pix),
        .i_cfg (cfg),
        .o_rgb (rgb)
    );

    yuvrgb_pack u_pack (
        .i_rgb   (rgb),
        .i_cfg   (cfg),
        .o_bytes (bytes)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_out_rgb   <= rgb;
            r_out_bytes <= bytes;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out_bytes.byte_count,
                            r_out_bytes.byte_third,
                            r_out_bytes.byte_second,
                            r_out_bytes.byte_first,
                            r_out_rgb.blue,
                            r_out_rgb.green,
                            r_out_rgb.red};

endmodule
